### sv/rrl_pkg.sv
// shared types and constants for the rotating ring list
package rrl_pkg;

  localparam int CAPACITY = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_ROTATE = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HEAD_RD,
    S_HEAD_WAIT
  } seq_state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } rrl_in_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic               head_valid;
    logic [6:0]         entry_count;
    logic               found;
    logic [1:0]         status;
  } rrl_out_t;

endpackage

### sv/rrl_store.sv
// ring store: one write port, one registered read port
module rrl_store #(
  parameter int DEPTH = rrl_pkg::CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/rrl_seq.sv
// sequencer: head and count registers, serial search compare, result build
module rrl_seq #(
  parameter int CAPACITY = rrl_pkg::CAPACITY,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rrl_pkg::rrl_in_t  in_data,
  output logic              busy,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [31:0]       wr_data,
  output logic [AW-1:0]     rd_addr,
  input  logic [31:0]       rd_data,
  output logic              done,
  output rrl_pkg::rrl_out_t result
);

  localparam logic [AW-1:0] LastPos = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FullCnt = CW'(CAPACITY);

  rrl_pkg::seq_state_t state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       scan_pos_r, scan_pos_nxt;
  logic [CW-1:0]       scan_left_r, scan_left_nxt;
  logic signed [31:0]  val_r, val_nxt;
  rrl_pkg::status_t    status_r, status_nxt;
  logic                found_r, found_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [CW+6:0]       count_ext;

  function automatic logic [AW-1:0] pos_next(input logic [AW-1:0] pos);
    pos_next = (pos == LastPos) ? '0 : pos + 1'b1;
  endfunction

  function automatic logic [AW-1:0] pos_prev(input logic [AW-1:0] pos);
    pos_prev = (pos == '0) ? LastPos : pos - 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rrl_pkg::S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_pos_r  <= scan_pos_nxt;
    scan_left_r <= scan_left_nxt;
    val_r       <= val_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    scan_pos_nxt  = scan_pos_r;
    scan_left_nxt = scan_left_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    cmp_vld_nxt   = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = pos_prev(head_r);
    wr_data       = in_data.value;
    rd_addr       = head_r;
    done          = 1'b0;
    busy          = (state_r != rrl_pkg::S_IDLE);

    // shared compare, one stored entry per cycle
    if (cmp_vld_r && (rd_data == val_r)) begin
      found_nxt = 1'b1;
    end

    case (state_r)
      rrl_pkg::S_IDLE: begin
        if (start) begin
          val_nxt    = in_data.value;
          status_nxt = rrl_pkg::ST_OK;
          found_nxt  = 1'b0;
          state_nxt  = rrl_pkg::S_HEAD_RD;
          case (rrl_pkg::op_t'(in_data.operation))
            rrl_pkg::OP_INSERT: begin
              if (count_r == FullCnt) begin
                status_nxt = rrl_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                head_nxt  = pos_prev(head_r);
                count_nxt = count_r + 1'b1;
              end
            end
            rrl_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = rrl_pkg::ST_EMPTY;
              end else begin
                head_nxt  = pos_next(head_r);
                count_nxt = count_r - 1'b1;
              end
            end
            rrl_pkg::OP_ROTATE: begin
              if (count_r != '0) begin
                head_nxt = pos_next(head_r);
              end
            end
            rrl_pkg::OP_SEARCH: begin
              if (count_r != '0) begin
                scan_pos_nxt  = head_r;
                scan_left_nxt = count_r;
                state_nxt     = rrl_pkg::S_SCAN;
              end
            end
            default: begin
              state_nxt = rrl_pkg::S_HEAD_RD;
            end
          endcase
        end
      end
      rrl_pkg::S_SCAN: begin
        rd_addr       = scan_pos_r;
        cmp_vld_nxt   = 1'b1;
        scan_pos_nxt  = pos_next(scan_pos_r);
        scan_left_nxt = scan_left_r - 1'b1;
        if (scan_left_r == CW'(1)) begin
          state_nxt = rrl_pkg::S_HEAD_RD;
        end
      end
      rrl_pkg::S_HEAD_RD: begin
        state_nxt = rrl_pkg::S_HEAD_WAIT;
      end
      rrl_pkg::S_HEAD_WAIT: begin
        done      = 1'b1;
        state_nxt = rrl_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rrl_pkg::S_IDLE;
      end
    endcase
  end

  assign count_ext = {7'b0, count_r};

  always_comb begin
    result.head_valid  = (count_r != '0);
    result.head_value  = result.head_valid ? rd_data : '0;
    result.entry_count = count_ext[6:0];
    result.found       = found_r;
    result.status      = status_r;
  end

endmodule

### sv/rotating_ring_list_top.sv
// top level of the rotating ring list: store, sequencer and result register
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+----------------------------------
//  request  | start, busy, in_data      | taken when start && !busy
//  result   | out_strobe, out_data      | one-cycle strobe, cannot stall
//
// every request passes the head read and head wait states and the result
// register; a search of a non-empty list first scans, the single compare
// unit checking one stored entry per cycle via the one registered read port
// busy stays high from accept until the result strobe; a new request can
// be taken in the strobe cycle
// reset (rst_n low, synchronous) empties the list; the store needs no clear
module rotating_ring_list_top #(
  parameter int CAPACITY = rrl_pkg::CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rrl_pkg::rrl_in_t  in_data,
  output logic              out_strobe,
  output rrl_pkg::rrl_out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // store port wiring
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  // sequencer result, registered before it leaves the block
  logic              done;
  rrl_pkg::rrl_out_t result;
  logic              out_strobe_r;
  rrl_pkg::rrl_out_t out_data_r;

  rrl_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rrl_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .busy    (busy),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (done),
    .result  (result)
  );

  // strobe is control, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= done;
    end
  end

  // result payload only loads with a finished request
  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= result;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

### sv/rrl_checker.sv
// port-level checks for the rotating ring list, bound to the top level
module rrl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input rrl_pkg::rrl_out_t out_data,
  input logic              out_strobe
);

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  // busy drops exactly when the result is shown
  a_fall_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without result strobe");

  // a single strobe per request, never back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // empty list reports no head value and no hit
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.head_valid |->
      out_data.head_value == 32'sd0 && out_data.entry_count == 7'd0 && !out_data.found)
    else $error("inconsistent empty-list result");

  // status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.status != 2'd3)
    else $error("undefined status code");

endmodule

bind rotating_ring_list_top rrl_checker u_rrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_data   (out_data),
  .out_strobe (out_strobe)
);

### test/rotating_ring_list_top_test.sv
// self-checking testbench for the rotating ring list top level
module rotating_ring_list_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrl_pkg::*;

  // segment styles for the random part: grow the list toward full,
  // shrink it toward empty, or an even mix of all operations
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  localparam int RANDOM_PER_PHASE = 235;
  // a search scans every stored entry, so this covers any request in flight
  localparam int DRAIN_CYCLES = CAPACITY + 16;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  rrl_in_t  in_data = '0;
  logic     out_strobe;
  rrl_out_t out_data;

  rotating_ring_list_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // own copy of the list: ring store, head slot and fill level
  logic signed [31:0] ring_copy [CAPACITY];
  int                 ring_head = 0;
  int                 ring_fill = 0;

  rrl_in_t  pending_reqs [$];   // requests not yet taken by the block
  rrl_out_t list_views   [$];   // predicted list views, oldest first
  logic     req_taken = 1'b0;   // head of pending_reqs was taken at the last edge
  int       idle_pct = 0;       // chance in percent that the sender skips a cycle
  int       mismatches = 0;

  // values that recur often enough for searches to hit, extremes included
  logic signed [31:0] value_pool [8] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
    32'sh0000_0001, 32'sh5a5a_5a5a, 32'sha5a5_a5a5, 32'sh0000_002a
  };

  // apply one request to the list copy and return the view the block reports
  function automatic rrl_out_t apply_list_op(rrl_in_t req);
    rrl_out_t view;
    op_t      op;
    int       pos;
    view = '0;
    view.status = ST_OK;
    op = op_t'(req.operation);
    case (op)
      OP_INSERT: begin
        if (ring_fill >= CAPACITY) begin
          view.status = ST_FULL;
        end else begin
          // new head goes one slot behind the old one
          ring_head = (ring_head == 0) ? CAPACITY - 1 : ring_head - 1;
          ring_copy[ring_head] = req.value;
          ring_fill++;
        end
      end
      OP_REMOVE: begin
        if (ring_fill == 0) begin
          view.status = ST_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % CAPACITY;
          ring_fill--;
        end
      end
      OP_ROTATE: begin
        // rotating an empty list changes nothing
        if (ring_fill != 0) ring_head = (ring_head + 1) % CAPACITY;
      end
      default: begin
        // only live entries are looked at
        pos = ring_head;
        for (int k = 0; k < ring_fill; k++) begin
          if (ring_copy[pos] == req.value) view.found = 1'b1;
          pos = (pos + 1) % CAPACITY;
        end
      end
    endcase
    view.head_valid  = (ring_fill != 0);
    view.head_value  = (ring_fill != 0) ? ring_copy[ring_head] : 32'sd0;
    view.entry_count = ring_fill[6:0];
    return view;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_req(op_t op, logic signed [31:0] v);
    rrl_in_t req;
    req.operation = op;
    req.value     = v;
    pending_reqs.push_back(req);
  endtask

  // random request with operation weights set by the segment style
  function automatic rrl_in_t make_req(mix_t mix);
    rrl_in_t req;
    int      roll;
    int      ins_w;
    int      rem_w;
    int      rot_w;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin ins_w = 65; rem_w = 10; rot_w = 10; end
      MIX_DRAIN: begin ins_w = 15; rem_w = 55; rot_w = 10; end
      default:   begin ins_w = 25; rem_w = 25; rot_w = 25; end
    endcase
    if (roll < ins_w) req.operation = OP_INSERT;
    else if (roll < ins_w + rem_w) req.operation = OP_REMOVE;
    else if (roll < ins_w + rem_w + rot_w) req.operation = OP_ROTATE;
    else req.operation = OP_SEARCH;
    // pool values make searches hit; fully random ones toggle every bit
    if ($urandom_range(99) < 40) req.value = value_pool[$urandom_range(7)];
    else req.value = $urandom;
    return req;
  endfunction

  // driver: new request at the falling edge, start may drop while busy
  always @(negedge clk) begin
    if (req_taken) begin
      void'(pending_reqs.pop_front());
      req_taken = 1'b0;
    end
    if (rst_n && pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start   <= 1'b1;
      in_data <= pending_reqs[0];
    end else begin
      start   <= 1'b0;
      in_data <= '0;
    end
  end

  // monitor: take requests and check results at the rising edge
  always @(posedge clk) begin
    // a result strobe in the same edge as a new request belongs to the
    // older request, which sits at the front of the queue
    if (rst_n && out_strobe) begin
      if (list_views.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        rrl_out_t want;
        want = list_views.pop_front();
        check_field("head_value", want.head_value, out_data.head_value);
        check_field("head_valid", want.head_valid, out_data.head_valid);
        check_field("entry_count", want.entry_count, out_data.entry_count);
        check_field("found", want.found, out_data.found);
        check_field("status", want.status, out_data.status);
      end
    end
    if (rst_n && start && !busy) begin
      list_views.push_back(apply_list_op(in_data));
      req_taken = 1'b1;
    end
  end

  // stimulus: directed corner cases, then random segments in idling phases
  initial begin
    int   idle_by_phase [4] = '{0, 55, 0, 21};
    int   made;
    int   seg_len;
    mix_t mix;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = idle_by_phase[phase];
      if (phase == 0) begin
        // empty list: search, remove error, rotate no-op
        queue_req(OP_SEARCH, 32'sd5);
        queue_req(OP_REMOVE, 32'sd0);
        queue_req(OP_ROTATE, 32'sd0);
        // value extremes
        queue_req(OP_INSERT, 32'sh8000_0000);
        queue_req(OP_INSERT, 32'sh7fff_ffff);
        queue_req(OP_INSERT, 32'sh0000_0000);
        queue_req(OP_INSERT, 32'shffff_ffff);
        queue_req(OP_SEARCH, 32'sh7fff_ffff);
        queue_req(OP_SEARCH, 32'sh0000_3039);
        queue_req(OP_SEARCH, 32'sh8000_0000);
        queue_req(OP_ROTATE, 32'sd0);
        queue_req(OP_ROTATE, 32'sd0);
        queue_req(OP_REMOVE, 32'sd0);
        queue_req(OP_INSERT, 32'shaaaa_aaaa);
        queue_req(OP_INSERT, 32'sh5555_5555);
        queue_req(OP_ROTATE, 32'sd0);
        queue_req(OP_SEARCH, 32'shaaaa_aaaa);
        // drain to empty, then one remove past the end
        repeat (5) queue_req(OP_REMOVE, 32'sd0);
        queue_req(OP_REMOVE, 32'sd0);
        queue_req(OP_ROTATE, 32'sd0);
      end
      made = 0;
      while (made < RANDOM_PER_PHASE) begin
        // segments long enough for a fill run to reach the full list
        mix = mix_t'($urandom_range(2));
        seg_len = (mix == MIX_FILL) ? $urandom_range(100, 160) : $urandom_range(20, 80);
        // last segment is cut so every phase gets the same request count
        if (seg_len > RANDOM_PER_PHASE - made) seg_len = RANDOM_PER_PHASE - made;
        repeat (seg_len) pending_reqs.push_back(make_req(mix));
        made += seg_len;
      end
      while (pending_reqs.size() != 0) @(posedge clk);
    end

    // let every request finish and make sure nothing stray follows
    while (start || list_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_200_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
